/* hw/rtl/hf2dt_pkg.sv */
// Shared constants for the binary16 to decimal text converter.
package hf2dt_pkg;

  localparam int HALF_W   = 16;
  localparam int MANT_W   = 11;
  localparam int EXP_W    = 5;
  localparam int FRAC_W   = 10;
  localparam int CHAR_W   = 7;
  localparam int INT_W    = 16;   // integer part, max 65504
  localparam int NDIG     = 5;    // decimal digits of the integer part
  localparam int BCD_W    = 4 * NDIG;
  localparam int REM_W    = 24;   // fraction remainder, aligned to 2^-24
  localparam int DIDX_W   = 3;    // digit index 0..4
  localparam int CNT_W    = 5;    // dabble bit counter 0..16

  localparam logic [EXP_W-1:0] EXP_ALL1  = 5'h1F;
  localparam logic [EXP_W-1:0] EXP_INT   = 5'd25;  // at or above: no fraction bits

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;

  // Letters of "Inf" / "NaN", position 0..2.
  function automatic logic [CHAR_W-1:0] spec_char(input logic is_nan,
                                                  input logic [1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      2'd0:    c = is_nan ? 7'h4E : 7'h49;
      2'd1:    c = is_nan ? 7'h61 : 7'h6E;
      default: c = is_nan ? 7'h4E : 7'h66;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/hf2dt_dabble.sv */
// Iterative binary to BCD converter, one shift-add-3 step per cycle.
module hf2dt_dabble (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hf2dt_pkg::INT_W-1:0] bin,
  output logic                        busy,
  output logic [hf2dt_pkg::BCD_W-1:0] bcd
);
  import hf2dt_pkg::*;

  logic [INT_W-1:0] bin_sh;
  logic [CNT_W-1:0] cnt;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(INT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_sh <= bin;
      bcd    <= '0;
    end else if (busy) begin
      bcd    <= {adj[BCD_W-2:0], bin_sh[INT_W-1]};
      bin_sh <= {bin_sh[INT_W-2:0], 1'b0};
    end
  end

endmodule

/* hw/rtl/hf2dt_frac_step.sv */
// One fraction digit step: remainder times ten, split into digit and new remainder.
module hf2dt_frac_step (
  input  logic [hf2dt_pkg::REM_W-1:0] rem,
  output logic [3:0]                  digit,
  output logic [hf2dt_pkg::REM_W-1:0] rem_next
);
  import hf2dt_pkg::*;

  logic [REM_W+3:0] prod;

  // x10 as x8 + x2
  assign prod     = {rem, 3'b000} + {3'b000, rem, 1'b0};
  assign digit    = prod[REM_W+3:REM_W];
  assign rem_next = prod[REM_W-1:0];

endmodule

/* hw/rtl/half_float_to_decimal_text_top.sv */
// Top level: binary16 pattern in, exact decimal ASCII text out, one character per request.
//
// Each input request carries one IEEE binary16 pattern; the block answers with the
// characters of its exact decimal value, one per output request, last_char marking
// the final one. Text is an optional '-', the integer digits (no leading zeros, "0"
// if the integer part is zero), then '.' and fraction digits until the remainder is
// exhausted (at most 24). Infinity is "Inf"/"-Inf", NaN is "NaN" regardless of sign,
// zero is "0"/"-0". One request is handled at a time and in_ready is low until its
// last character has gone into the output register. A finite value first has its 16-bit
// integer part converted to BCD bit-serially, then its characters are emitted; each
// fraction digit costs one pass through the shared times-ten unit. Inf/NaN characters
// are emitted directly. The output register lets the next request be taken while the
// final character is still waiting.
module half_float_to_decimal_text_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hf2dt_pkg::HALF_W-1:0] half_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hf2dt_pkg::CHAR_W-1:0] text_char,
  output logic                        last_char
);
  import hf2dt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DABBLE, S_SIGN, S_INT, S_DOT, S_FRAC, S_SPEC
  } state_t;

  state_t state, state_next;

  // request context
  logic              neg;
  logic              spec;
  logic              nan;
  logic [REM_W-1:0]  rem;
  logic [DIDX_W-1:0] idx;
  logic [1:0]        spos;

  // field decode at accept
  logic              accept;
  logic [EXP_W-1:0]  ex;
  logic [FRAC_W-1:0] fr;
  logic [MANT_W-1:0] mant;
  logic [4:0]        sh;
  logic [MANT_W+REM_W-1:0] wide;
  logic [INT_W-1:0]  ipart;
  logic [REM_W-1:0]  rem_init;

  // shared units
  logic              dab_busy;
  logic [BCD_W-1:0]  bcd;
  logic [3:0]        fdigit;
  logic [REM_W-1:0]  frem_next;

  // emission
  logic              out_free;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic [DIDX_W-1:0] lead_idx;
  logic [3:0]        int_digit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign ex   = half_bits[14:10];
  assign fr   = half_bits[9:0];
  assign mant = (ex == '0) ? {1'b0, fr} : {1'b1, fr};

  // Value = mant * 2^(ex-25) (subnormal: fr * 2^-24). Shifting mant left by ex-1 (0 for
  // subnormals) puts the binary point at bit 24, so the upper bits are the integer part
  // and the lower the remainder.
  always_comb begin
    sh       = (ex == '0) ? 5'd0 : ex - 5'd1;
    wide     = {{REM_W{1'b0}}, mant} << sh;
    ipart    = {{(INT_W-MANT_W){1'b0}}, wide[MANT_W+REM_W-1:REM_W]};
    rem_init = wide[REM_W-1:0];
    if (ex >= EXP_INT) begin
      ipart    = {{(INT_W-MANT_W){1'b0}}, mant} << (ex - EXP_INT);
      rem_init = '0;
    end
  end

  hf2dt_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (ex != EXP_ALL1)),
    .bin   (ipart),
    .busy  (dab_busy),
    .bcd   (bcd)
  );

  hf2dt_frac_step u_frac (
    .rem      (rem),
    .digit    (fdigit),
    .rem_next (frem_next)
  );

  // highest nonzero BCD digit, zero position when all are zero
  always_comb begin
    lead_idx = '0;
    for (int k = 1; k < NDIG; k++) begin
      if (bcd[4*k +: 4] != 4'd0) lead_idx = DIDX_W'(k);
    end
  end

  assign int_digit = bcd[{idx, 2'b00} +: 4];

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_char  = CH_ZERO;
    emit_last  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (ex != EXP_ALL1)          state_next = S_DABBLE;
          else if (fr == '0 && half_bits[15]) state_next = S_SIGN;
          else                         state_next = S_SPEC;
        end
      end
      S_DABBLE: begin
        if (!dab_busy) state_next = neg ? S_SIGN : S_INT;
      end
      S_SIGN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = CH_MINUS;
          state_next = spec ? S_SPEC : S_INT;
        end
      end
      S_INT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO | {3'b000, int_digit};
          if (idx == '0) begin
            emit_last  = (rem == '0);
            state_next = (rem == '0) ? S_IDLE : S_DOT;
          end
        end
      end
      S_DOT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = CH_DOT;
          state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO | {3'b000, fdigit};
          emit_last = (frem_next == '0);
          if (frem_next == '0) state_next = S_IDLE;
        end
      end
      S_SPEC: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = spec_char(nan, spos);
          emit_last = (spos == 2'd2);
          if (spos == 2'd2) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (emit) begin
        text_char <= emit_char;
        last_char <= emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          neg  <= half_bits[15];
          spec <= (ex == EXP_ALL1);
          nan  <= (fr != '0);
          rem  <= rem_init;
          spos <= 2'd0;
        end
      end
      S_DABBLE: idx <= lead_idx;
      S_INT:    if (emit && idx != '0) idx <= idx - 1'b1;
      S_FRAC:   if (emit) rem <= frem_next;
      S_SPEC:   if (emit) spos <= spos + 2'd1;
      default: ;
    endcase
  end

endmodule
